@@ rtl/max_subarray_sum_at_least_k_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the max subarray sum block
// Shared property shapes, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef MAX_SUBARRAY_SUM_AT_LEAST_K_DEFINES_SVH
`define MAX_SUBARRAY_SUM_AT_LEAST_K_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define MSK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MSK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/msk_pkg.sv @@
// ---------------------------------------------------------------------------
// msk_pkg
// Widths, defaults and the saturation helper of the max subarray sum block.
// ---------------------------------------------------------------------------
package msk_pkg;

  // Default ring depth and sample width
  localparam int MAX_RUN_DEF     = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed widths of the sums and of the run length register
  localparam int SUM_BITS = 48;
  localparam int CFG_BITS = 9;
  localparam int EXT_BITS = SUM_BITS + 2;

  localparam logic [CFG_BITS-1:0] RUN_LEN_RESET = CFG_BITS'(1);

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  // Clamp a widened sum back into the signed sum range
  function automatic logic signed [SUM_BITS-1:0] sat_sum(
    input logic signed [EXT_BITS-1:0] v
  );
    logic signed [SUM_BITS-1:0] r;
    if (v > EXT_BITS'(SUM_MAX)) begin
      r = SUM_MAX;
    end else if (v < EXT_BITS'(SUM_MIN)) begin
      r = SUM_MIN;
    end else begin
      r = v[SUM_BITS-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/max_subarray_sum_at_least_k.sv @@
// ---------------------------------------------------------------------------
// max_subarray_sum_at_least_k
// Streaming largest sum of a contiguous run of at least k samples.
// ---------------------------------------------------------------------------
// Usage:
//   Samples arrive on the s_ request channel, one signed sample in s_tdata,
//   s_tlast on the final sample of a sequence. For each sequence one result
//   leaves on the m_ channel: m_tdata holds the 48-bit best sum, m_tuser is
//   high when the sequence held at least k samples (otherwise the sum is 0).
//   k is written through cfg_we/cfg_wdata between sequences; 0 acts as 1 and
//   values above MAX_RUN act as MAX_RUN.
//   Throughput: one sample per cycle. The last k samples and their Kadane
//   values sit in one RAM; the read for a sample is issued as it is taken
//   and the arithmetic runs in the cycle after, with a bypass when that slot is
//   being written in the same cycle.
//   Result path: the last sample passes the stage 1 register, then the output register.
//   Stall: while a result waits on m_tready, non-last samples keep flowing;
//   the next last sample waits in the arithmetic stage and holds the input
//   until the output register frees.
//   Reset: k returns to 1 and the sequence state clears; the RAM is not
//   cleared, no clearing pass is needed.
// ---------------------------------------------------------------------------
module max_subarray_sum_at_least_k #(
  parameter int MAX_RUN     = msk_pkg::MAX_RUN_DEF,
  parameter int SAMPLE_BITS = msk_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // run length register
  input  logic                              cfg_we,
  input  logic [msk_pkg::CFG_BITS-1:0]      cfg_wdata,
  // sample requests
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                              s_tlast,   // last_item
  // results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [msk_pkg::SUM_BITS-1:0]      m_tdata,   // [47:0] max_sum
  output logic                              m_tuser    // sum_valid
);

  import msk_pkg::*;

  localparam int SLOT_W = $clog2(MAX_RUN);
  localparam int CNT_W  = $clog2(MAX_RUN + 1);
  localparam int KW     = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;
  localparam int RAM_W  = SUM_BITS + SAMPLE_BITS;

  // Run length register and its clamped value
  logic [CFG_BITS-1:0] run_len;
  logic [KW-1:0]       k_wide;
  logic [KW-1:0]       k_clamp;
  logic [CNT_W-1:0]    k_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_len <= RUN_LEN_RESET;
    end else if (cfg_we) begin
      run_len <= cfg_wdata;
    end
  end

  assign k_wide  = KW'(run_len);
  assign k_clamp = (k_wide == '0) ? KW'(1) :
                   (k_wide > KW'(MAX_RUN)) ? KW'(MAX_RUN) : k_wide;
  assign k_eff   = CNT_W'(k_clamp);

  // Handshake
  logic s1_valid, s1_last, s1_go, out_free, s_acc;

  assign out_free = !m_tvalid || m_tready;
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign s_tready = !s1_valid || s1_go;
  assign s_acc    = s_tvalid && s_tready;

  // Stage 0: slot and phase tracking, RAM read issue
  logic [SLOT_W-1:0] slot, slot_eff, slot_nxt;
  logic [CNT_W-1:0]  slot_inc;
  logic [CNT_W-1:0]  items_seen;
  logic              grow, first, hit;

  assign slot_eff = (CNT_W'(slot) >= k_eff) ? '0 : slot;
  assign slot_inc = CNT_W'(slot_eff) + CNT_W'(1);
  assign slot_nxt = (slot_inc >= k_eff) ? '0 : slot_inc[SLOT_W-1:0];
  assign grow     = items_seen < k_eff;
  assign first    = items_seen == '0;
  assign hit      = grow && ((items_seen + CNT_W'(1)) == k_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      items_seen <= '0;
    end else if (s_acc) begin
      if (s_tlast) begin
        slot       <= '0;
        items_seen <= '0;
      end else begin
        slot       <= slot_nxt;
        items_seen <= grow ? items_seen + CNT_W'(1) : k_eff;
      end
    end
  end

  // Stage 1 registers
  logic [SAMPLE_BITS-1:0] s1_x;
  logic                   s1_first, s1_grow, s1_hit, s1_fwd;
  logic [SLOT_W-1:0]      s1_slot;
  logic [RAM_W-1:0]       s1_fwd_data;
  logic [RAM_W-1:0]       ram_rdata, ram_wdata, old_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_x        <= s_tdata[SAMPLE_BITS-1:0];
      s1_last     <= s_tlast;
      s1_first    <= first;
      s1_grow     <= grow;
      s1_hit      <= hit;
      s1_slot     <= slot_eff;
      // bypass when the slot is written in this same cycle
      s1_fwd      <= s1_go && (s1_slot == slot_eff);
      s1_fwd_data <= ram_wdata;
    end
  end

  // Stage 1 arithmetic
  logic signed [SUM_BITS-1:0] run_best, win_sum, best;
  logic signed [SUM_BITS-1:0] x_ext, old_x, old_kad;
  logic signed [SUM_BITS-1:0] kad_sum, kad, win_new, cand, best_new;
  logic                       res_valid;

  assign old_entry = s1_fwd ? s1_fwd_data : ram_rdata;
  assign x_ext     = {{(SUM_BITS-SAMPLE_BITS){s1_x[SAMPLE_BITS-1]}}, s1_x};
  assign old_x     = {{(SUM_BITS-SAMPLE_BITS){old_entry[SAMPLE_BITS-1]}},
                      old_entry[SAMPLE_BITS-1:0]};
  assign old_kad   = old_entry[RAM_W-1:SAMPLE_BITS];

  // Kadane value ending at this sample
  assign kad_sum = sat_sum(EXT_BITS'(run_best) + EXT_BITS'(x_ext));
  assign kad     = (s1_first || (x_ext > kad_sum)) ? x_ext : kad_sum;

  // Window of the latest k samples
  assign win_new = s1_grow ? sat_sum(EXT_BITS'(win_sum) + EXT_BITS'(x_ext))
                           : sat_sum(EXT_BITS'(win_sum) + EXT_BITS'(x_ext)
                                     - EXT_BITS'(old_x));
  assign cand    = sat_sum(EXT_BITS'(win_new) + EXT_BITS'(old_kad));

  always_comb begin
    best_new = best;
    if (s1_grow) begin
      if (s1_hit) begin
        best_new = win_new;
      end
    end else begin
      if (win_new > best_new) begin
        best_new = win_new;
      end
      if (cand > best_new) begin
        best_new = cand;
      end
    end
  end

  assign res_valid = !s1_grow || s1_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_best <= '0;
      win_sum  <= '0;
      best     <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        run_best <= '0;
        win_sum  <= '0;
        best     <= '0;
      end else begin
        run_best <= kad;
        win_sum  <= win_new;
        best     <= best_new;
      end
    end
  end

  // Ring of samples and Kadane values
  assign ram_wdata = {kad, s1_x};

  msk_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_RUN)
  ) u_ring (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_slot),
    .wdata (ram_wdata),
    .re    (s_acc),
    .raddr (slot_eff),
    .rdata (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      m_tdata <= res_valid ? best_new : '0;
      m_tuser <= res_valid;
    end
  end

endmodule

@@ rtl/msk_ram.sv @@
// ---------------------------------------------------------------------------
// msk_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module msk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while re is low, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/msk_checker.sv @@
// ---------------------------------------------------------------------------
// msk_checker
// Port-level checks of the max subarray sum block, bound to the top level.
// ---------------------------------------------------------------------------
`include "max_subarray_sum_at_least_k_defines.svh"

module msk_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              s_tlast,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [msk_pkg::SUM_BITS-1:0]      m_tdata,
  input logic                              m_tuser
);

  // A stalled result holds
  `MSK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // A short sequence reports a zero sum
  `MSK_ASSERT_NOW(a_short_zero, m_tvalid && !m_tuser,
    m_tdata == '0, "short sequence with nonzero sum")

  // A new result follows a taken last sample
  `MSK_ASSERT_NOW(a_out_cause, $rose(m_tvalid),
    $past(s_tvalid && s_tready && s_tlast, 2), "result without a last sample")

  // Input back-pressure only while a result is stuck
  `MSK_ASSERT_NOW(a_ready_cause, !s_tready,
    m_tvalid && !m_tready, "input stalled without output stall")

  // No result straight out of reset
  `MSK_ASSERT_NOW(a_reset_quiet, $past(rst),
    !m_tvalid, "result valid after reset")

endmodule

bind max_subarray_sum_at_least_k msk_checker u_msk_checker (.*);

@@ tb/max_subarray_sum_at_least_k_checker.sv @@
// ---------------------------------------------------------------------------
// max_subarray_sum_at_least_k_checker
// Watches the run length register, the sample requests and the result
// channel. It predicts each sequence's best sum of a run of at least k
// samples and compares every result field by field, oldest first.
// ---------------------------------------------------------------------------
module max_subarray_sum_at_least_k_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [msk_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // [15:0] sample
  input  logic                         s_tlast,   // last_item
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [msk_pkg::SUM_BITS-1:0] m_tdata,   // [47:0] max_sum
  input  logic                         m_tuser,   // sum_valid
  output int                           mismatches,
  output int                           outstanding,
  output int                           results_checked,
  output int                           valid_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = msk_pkg::MAX_RUN_DEF;

  typedef struct packed {
    logic signed [47:0] sum;
    logic               ok;
  } sum_result_t;

  // Predicted results still owed by the block
  sum_result_t pending_sums[$];

  // Predictor state
  logic [msk_pkg::CFG_BITS-1:0] run_len;
  logic signed [15:0]           sample_hist [DEPTH];
  logic signed [47:0]           kadane_hist [DEPTH];
  logic signed [47:0]           kadane_tail;
  logic signed [47:0]           window_sum;
  logic signed [47:0]           best_sum;
  int                           fill;
  int                           slot;
  int                           err_count;
  int                           res_count;
  int                           ok_count;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      sample_hist[i] = '0;
      kadane_hist[i] = '0;
    end
    err_count  = 0;
    res_count  = 0;
    ok_count   = 0;
    mismatches = 0;
    outstanding = 0;
    results_checked = 0;
    valid_results = 0;
  end

  // Clamp a widened sum into the 48-bit signed range
  function automatic logic signed [47:0] clamp48(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = {3'b000, {47{1'b1}}};
    lo = {3'b111, {47{1'b0}}};
    if (v > hi) return hi[47:0];
    if (v < lo) return lo[47:0];
    return v[47:0];
  endfunction

  function automatic logic signed [47:0] max48(input logic signed [47:0] a,
                                               input logic signed [47:0] b);
    return (a > b) ? a : b;
  endfunction

  task automatic clear_run();
    kadane_tail = '0;
    window_sum  = '0;
    best_sum    = '0;
    fill        = 0;
    slot        = 0;
  endtask

  // One sample through the predictor; a last sample yields one result
  task automatic take_sample(input logic signed [15:0] x, input logic is_last);
    int                 eff_k;
    logic signed [49:0] xe;
    logic signed [49:0] acc;
    logic signed [49:0] old_x;
    logic signed [49:0] old_kad;
    logic signed [47:0] kad;
    sum_result_t        res;
    eff_k = (run_len == 0) ? 1 : ((run_len > DEPTH) ? DEPTH : int'(run_len));
    if (slot >= eff_k) slot = 0;
    xe = x;

    // best run ending here
    if (fill == 0) begin
      kad = clamp48(xe);
    end else begin
      acc = kadane_tail;
      acc = acc + xe;
      kad = clamp48((acc > xe) ? acc : xe);
    end
    kadane_tail = kad;

    // fill the first window, then slide it
    if (fill < eff_k) begin
      acc = window_sum;
      window_sum = clamp48(acc + xe);
      if (fill + 1 == eff_k) best_sum = window_sum;
      fill++;
    end else begin
      old_x   = sample_hist[slot];
      old_kad = kadane_hist[slot];
      acc = window_sum;
      window_sum = clamp48(acc + xe - old_x);
      best_sum = max48(best_sum, window_sum);
      acc = window_sum;
      best_sum = max48(best_sum, clamp48(acc + old_kad));
      fill = eff_k;
    end

    sample_hist[slot] = x;
    kadane_hist[slot] = kad;
    slot++;
    if (slot >= eff_k) slot = 0;

    if (is_last) begin
      res.ok  = (fill >= eff_k);
      res.sum = res.ok ? best_sum : '0;
      pending_sums.push_back(res);
      clear_run();
    end
  endtask

  // Report a mismatch; only the first ten are printed
  task automatic flag(input string what, input logic [47:0] want, input logic [47:0] got);
    err_count++;
    if (err_count <= 10)
      $display("[%0t] %s: expected 0x%012h, got 0x%012h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    sum_result_t want;
    if (rst) begin
      run_len = msk_pkg::RUN_LEN_RESET;
      clear_run();
    end else begin
      if (cfg_we) run_len = cfg_wdata;

      if (s_tvalid && s_tready) take_sample(s_tdata, s_tlast);

      if (m_tvalid && m_tready) begin
        res_count++;
        if (pending_sums.size() == 0) begin
          flag("result with no request pending", '0, m_tdata);
        end else begin
          want = pending_sums.pop_front();
          if (m_tuser) ok_count++;
          if (m_tuser !== want.ok) flag("sum_valid", 48'(want.ok), 48'(m_tuser));
          if (m_tdata !== want.sum) flag("max_sum", want.sum, m_tdata);
        end
      end
    end
    mismatches      <= err_count;
    outstanding     <= pending_sums.size();
    results_checked <= res_count;
    valid_results   <= ok_count;
  end

endmodule

@@ tb/max_subarray_sum_at_least_k_tb.sv @@
// ---------------------------------------------------------------------------
// max_subarray_sum_at_least_k_tb
// Streams signed sample sequences into the block under several run lengths,
// extremes included, with random gaps and back-pressure; the checker beside
// the block predicts and compares every result.
// ---------------------------------------------------------------------------
module max_subarray_sum_at_least_k_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS = 550;
  localparam int MIN_SEQS   = 48;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_we    = 1'b0;
  logic [msk_pkg::CFG_BITS-1:0] cfg_wdata = '0;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [15:0]                  s_tdata   = '0;   // [15:0] sample
  logic                         s_tlast   = 1'b0; // last_item
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [msk_pkg::SUM_BITS-1:0] m_tdata;          // [47:0] max_sum
  logic                         m_tuser;          // sum_valid

  int mismatches;
  int outstanding;
  int results_checked;
  int valid_results;

  int src_gap_pct  = 0;
  int sink_stall_pct = 0;
  int items_sent   = 0;
  int rand_items   = 0;
  int seqs_sent    = 0;

  max_subarray_sum_at_least_k uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  max_subarray_sum_at_least_k_checker chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .valid_results   (valid_results)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Offer one sample, with a random gap first; returns once it is taken
  task automatic push_sample(input logic signed [15:0] value, input logic is_last);
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (is_last) seqs_sent++;
  endtask

  // Mix of extremes, small values and full-range noise
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:          return 16'sh7FFF;
      1:          return 16'sh8000;
      2, 3, 4, 5: return 16'(int'($urandom_range(200)) - 100);
      default:    return 16'($urandom);
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) push_sample(pick_sample(), i == len - 1);
  endtask

  // Let every owed result come back, then let the pipeline idle
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_run_len(input logic [msk_pkg::CFG_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One register setting followed by a few sequences of random content
  task automatic random_round();
    logic [msk_pkg::CFG_BITS-1:0] setting;
    int eff_k;
    int len;
    int n_seq;
    case ($urandom_range(15))
      0:       setting = '0;
      1:       setting = 9'd1;
      14:      setting = 9'($urandom_range(9, 16));
      15:      setting = 9'($urandom_range(256, 511));
      default: setting = 9'($urandom_range(2, 8));
    endcase
    eff_k = (setting == 0) ? 1 : ((setting > 256) ? 256 : int'(setting));
    settle();
    write_run_len(setting);
    n_seq = $urandom_range(1, 4);
    for (int s = 0; s < n_seq; s++) begin
      if (eff_k > 16)
        len = $urandom_range(1, 4);
      else if (eff_k > 1 && $urandom_range(6) == 0)
        len = $urandom_range(1, eff_k - 1);
      else
        len = eff_k + $urandom_range(0, 2 * eff_k + 4);
      send_run(len);
      rand_items += len;
    end
  endtask

  initial begin
    int long_len;
    src_gap_pct    = 36;
    sink_stall_pct = 48;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: k at its reset value of 1, single-sample sequences at both extremes, then a mixed one
    push_sample(16'sh7FFF, 1'b1);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sd5, 1'b0);
    push_sample(-16'sd3, 1'b0);
    push_sample(16'sd7, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7FFF, 1'b1);

    // k = 3: a short sequence, a full-scale one, a mixed sliding one
    settle();
    write_run_len(9'd3);
    push_sample(16'sd9, 1'b0);
    push_sample(-16'sd4, 1'b1);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh7FFF, 1'b1);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sd4, 1'b0);
    push_sample(-16'sd2, 1'b0);
    push_sample(16'sd9, 1'b1);

    // Zero acts as one
    settle();
    write_run_len(9'd0);
    push_sample(-16'sd5, 1'b0);
    push_sample(-16'sd7, 1'b1);

    // Above the ring depth: acts as 256, so these are short
    settle();
    write_run_len(9'd511);
    push_sample(16'sd100, 1'b1);
    settle();
    write_run_len(9'd257);
    push_sample(-16'sd100, 1'b0);
    push_sample(16'sd3, 1'b1);

    // Random part in three phases of different source gap and sink stall rates
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_gap_pct    = 36;
          sink_stall_pct = 48;
        end
        1: begin
          src_gap_pct    = 48;
          sink_stall_pct = 36;
        end
        default: begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end
      endcase
      if (ph == 1) begin
        // one sequence that wraps the full ring
        settle();
        write_run_len(9'd256);
        long_len = 256 + $urandom_range(1, 24);
        send_run(long_len);
        rand_items += long_len;
      end
      while (rand_items < (ph + 1) * RAND_ITEMS / 3 || (ph == 2 && seqs_sent < MIN_SEQS))
        random_round();
    end

    settle();
    $display("Sent %0d samples in %0d sequences over run lengths 0 to 511 (incl. a full ring).",
             items_sent, seqs_sent);
    $display("Checked %0d results, %0d with sum_valid set.", results_checked, valid_results);
    if (mismatches == 0 && outstanding == 0) begin
      $display("max_subarray_sum_at_least_k: match");
    end else begin
      $display("max_subarray_sum_at_least_k: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timed out waiting on the block.");
    $display("max_subarray_sum_at_least_k: mismatch");
    $finish;
  end

endmodule
